>>> rtl/core/px2x_pkg.sv
// Shared types and constants of the Super 2xSaI column doubler.
package px2x_pkg;

	localparam int MAX_ROW_WIDTH = 1024;
	localparam int CNT_W         = 11;
	localparam int COL_IDX_W     = 10;

	typedef logic [31:0]          pix_t;
	typedef logic [3:0][31:0]     col_t;
	typedef logic [3:0][3:0][31:0] grid_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		grid_t cols;
		cnt_t  n;
		logic  last;
	} item_t;

	typedef struct packed {
		pix_t tl;
		pix_t tr;
		pix_t bl;
		pix_t br;
	} quad_t;

endpackage

>>> rtl/core/px2x_window.sv
// Column window: the three previous columns and the per-row column counter.
module px2x_window import px2x_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  pix_t   pixel_above,
	input  pix_t   pixel_this,
	input  pix_t   pixel_below,
	input  pix_t   pixel_below_two,
	input  logic   end_of_row,
	output item_t  item
);

	col_t win_q [3];
	cnt_t seen_q;
	col_t cur;

	assign cur = {pixel_below_two, pixel_below, pixel_this, pixel_above};

	always_comb begin
		item.cols = {cur, win_q[2], win_q[1], win_q[0]};
		item.n    = seen_q;
		item.last = end_of_row || (seen_q >= CNT_W'(MAX_ROW_WIDTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			seen_q   <= '0;
		end else if (accept) begin
			if (item.last) begin
				// clear for the next row
				win_q[0] <= '0;
				win_q[1] <= '0;
				win_q[2] <= '0;
				seen_q   <= '0;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= cur;
				seen_q   <= seen_q + cnt_t'(1);
			end
		end
	end

endmodule

>>> rtl/core/px2x_kernel.sv
// Super 2xSaI rules for one 4x4 neighborhood, giving one 2x2 output block.
module px2x_kernel import px2x_pkg::*; (
	input  grid_t g,
	output quad_t q
);

	localparam pix_t RGB_MASK = 32'h00ff_ffff;
	localparam pix_t HALF_HI  = 32'h00FE_FEFE;
	localparam pix_t HALF_LO  = 32'h0001_0101;
	localparam pix_t QUART_HI = 32'h00FC_FCFC;
	localparam pix_t QUART_LO = 32'h0003_0303;

	function automatic pix_t half_blend(input pix_t a, input pix_t b);
		return ((a & HALF_HI) >> 1) + ((b & HALF_HI) >> 1) + (a & b & HALF_LO);
	endfunction

	function automatic pix_t quarter_blend(input pix_t a, input pix_t b,
	                                       input pix_t c, input pix_t d);
		pix_t hi;
		pix_t lo;
		hi = ((a & QUART_HI) >> 2) + ((b & QUART_HI) >> 2) +
		     ((c & QUART_HI) >> 2) + ((d & QUART_HI) >> 2);
		lo = (a & QUART_LO) + (b & QUART_LO) + (c & QUART_LO) + (d & QUART_LO);
		return hi + ((lo >> 2) & QUART_LO);
	endfunction

	function automatic logic signed [3:0] vote(input pix_t a, input pix_t b,
	                                          input pix_t c, input pix_t d);
		logic pa;
		logic pb;
		pa = ((a & RGB_MASK) != (c & RGB_MASK)) || ((a & RGB_MASK) != (d & RGB_MASK));
		pb = ((b & RGB_MASK) != (c & RGB_MASK)) || ((b & RGB_MASK) != (d & RGB_MASK));
		return $signed({3'b000, pa}) - $signed({3'b000, pb});
	endfunction

	pix_t b0, b1, b2, b3, c4, c5, c6, s2, c1, c2, c3, s1, a0, a1, a2, a3;
	logic signed [3:0] score;

	assign b0 = g[0][0]; assign b1 = g[1][0]; assign b2 = g[2][0]; assign b3 = g[3][0];
	assign c4 = g[0][1]; assign c5 = g[1][1]; assign c6 = g[2][1]; assign s2 = g[3][1];
	assign c1 = g[0][2]; assign c2 = g[1][2]; assign c3 = g[2][2]; assign s1 = g[3][2];
	assign a0 = g[0][3]; assign a1 = g[1][3]; assign a2 = g[2][3]; assign a3 = g[3][3];

	assign score = vote(c6, c5, c1, a1) + vote(c6, c5, c4, b1) +
	               vote(c6, c5, a2, s1) + vote(c6, c5, b2, s2);

	always_comb begin
		priority if (c2 == c6 && c5 != c3) begin
			q.tr = c2;
			q.br = c2;
		end else if (c5 == c3 && c2 != c6) begin
			q.tr = c5;
			q.br = c5;
		end else if (c5 == c3 && c2 == c6) begin
			priority if (score > 4'sd0) begin
				q.tr = c6;
				q.br = c6;
			end else if (score < 4'sd0) begin
				q.tr = c5;
				q.br = c5;
			end else begin
				q.tr = half_blend(c5, c6);
				q.br = q.tr;
			end
		end else begin
			priority if (c6 == c3 && c3 == a1 && c2 != a2 && c3 != a0)
				q.br = quarter_blend(c3, c3, c3, c2);
			else if (c5 == c2 && c2 == a2 && a1 != c3 && c2 != a3)
				q.br = quarter_blend(c2, c2, c2, c3);
			else
				q.br = half_blend(c2, c3);

			priority if (c6 == c3 && c6 == b1 && c5 != b2 && c6 != b0)
				q.tr = quarter_blend(c6, c6, c6, c5);
			else if (c5 == c2 && c5 == b2 && b1 != c6 && c5 != b3)
				q.tr = quarter_blend(c6, c5, c5, c5);
			else
				q.tr = half_blend(c5, c6);
		end

		priority if (c5 == c3 && c2 != c6 && c4 == c5 && c5 != a2)
			q.bl = half_blend(c2, c5);
		else if (c5 == c1 && c6 == c5 && c4 != c2 && c5 != a0)
			q.bl = half_blend(c2, c5);
		else
			q.bl = c2;

		priority if (c2 == c6 && c5 != c3 && c1 == c2 && c2 != b2)
			q.tl = half_blend(c2, c5);
		else if (c4 == c2 && c3 == c2 && c1 != c5 && c2 != b0)
			q.tl = half_blend(c2, c5);
		else
			q.tl = c5;
	end

endmodule

>>> rtl/core/pixel_art_2x_upscaler_top.sv
// Top level of the Super 2xSaI doubler: item register, block sequencer, result register.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, pixel_above .. end_of_row  | column in
//  out     | out_valid, out_stall, source_column .. row_fin | block out
//
// One source column is taken per cycle while in_stall is low; a mid-row column yields at
// most one block. The column that ends a row yields up to three blocks, one per cycle
// via the single kernel while out_stall is low, and holds the item register until done.
// Reset clears the column window, the column counter and both valid flags.
// out_stall holds the result register; the input stalls only while the item
// register still has blocks to hand over.
module pixel_art_2x_upscaler_top import px2x_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          pixel_above,
	input  logic [31:0]          pixel_this,
	input  logic [31:0]          pixel_below,
	input  logic [31:0]          pixel_below_two,
	input  logic                 end_of_row,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COL_IDX_W-1:0] source_column,
	output logic [31:0]          out_top_left,
	output logic [31:0]          out_top_right,
	output logic [31:0]          out_bottom_left,
	output logic [31:0]          out_bottom_right,
	output logic                 row_finished
);

	item_t item;
	logic  accept;

	grid_t      cols_s1;
	cnt_t       n_s1;
	logic [1:0] nmin_s1;
	logic       last_s1;
	logic [1:0] d_s1;
	logic       valid_s1;

	logic  advance;
	logic  done;
	grid_t g;
	quad_t blk;
	cnt_t  x;
	logic [1:0] lb;

	px2x_window u_window (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.pixel_above     (pixel_above),
		.pixel_this      (pixel_this),
		.pixel_below     (pixel_below),
		.pixel_below_two (pixel_below_two),
		.end_of_row      (end_of_row),
		.item            (item)
	);

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign done     = advance && (!last_s1 || d_s1 == 2'd0);
	assign in_stall = valid_s1 && !done;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			d_s1     <= '0;
			last_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1 <= item.last || (item.n >= cnt_t'(2));
			last_s1  <= item.last;
			// start with the oldest block still owed: d is the distance back from column n
			if (item.last && item.n < cnt_t'(2))
				d_s1 <= item.n[1:0];
			else
				d_s1 <= 2'd2;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			d_s1 <= d_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cols_s1 <= item.cols;
			n_s1    <= item.n;
			nmin_s1 <= (item.n >= cnt_t'(3)) ? 2'd3 : item.n[1:0];
		end
	end

	// clamp neighbor columns to the row: window slot = max(min(k+2-d, 3), 3-min(n,3))
	assign lb = 2'd3 - nmin_s1;

	always_comb begin
		logic [2:0] t;
		logic [1:0] idx;
		for (int k = 0; k < 4; k++) begin
			t   = 3'(k) + 3'd2 - {1'b0, d_s1};
			idx = (t > 3'd3) ? 2'd3 : t[1:0];
			if (idx < lb)
				idx = lb;
			g[k] = cols_s1[idx];
		end
	end

	assign x = n_s1 - cnt_t'(d_s1);

	px2x_kernel u_kernel (
		.g (g),
		.q (blk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			source_column    <= x[COL_IDX_W-1:0];
			out_top_left     <= blk.tl;
			out_top_right    <= blk.tr;
			out_bottom_left  <= blk.bl;
			out_bottom_right <= blk.br;
			row_finished     <= last_s1 && (d_s1 == 2'd0);
		end
	end

endmodule
